/* sv/euler_to_quaternion_assert.svh */
// ----------------------------------------------------------------------------
// Euler to quaternion assertion macros
// Shared property templates for the port checker of the converter.
// ----------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH

// Implication checked at every clock edge outside of reset.
`define EUQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that holds at every clock edge outside of reset.
`define EUQ_ASSERT_ALWAYS(lbl, cond, msg) \
  `EUQ_ASSERT_IMP(lbl, 1'b1, cond, msg)

`endif

/* sv/euq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler to quaternion package
// Widths, CORDIC constants and product term tables of the converter.
// ----------------------------------------------------------------------------
package euq_pkg;

  localparam int TRIG_ITERATIONS = 14;
  localparam int ATAN_LEN        = 24;
  localparam int CORDIC_ITERS    = (TRIG_ITERATIONS > ATAN_LEN) ? ATAN_LEN : TRIG_ITERATIONS;

  localparam int ANGLE_W = 16;
  localparam int QUAT_W  = 16;
  localparam int CW      = 33;
  localparam int ZW      = 34;
  localparam int TW      = 22;
  localparam int RND_SH  = 10;
  localparam int PPW     = 2 * TW;
  localparam int LO_W    = TW - 1;
  localparam int HI_W    = PPW - LO_W;
  localparam int PW      = PPW + TW + 1;
  localparam int SW      = PW + 1;
  localparam int OUT_SH  = 46;
  localparam int RW      = SW - OUT_SH;
  localparam int Q14_ONE = 16384;

  localparam int LANES   = 3;
  localparam int TERMS   = 8;
  localparam int QUATS   = 4;
  localparam int LATENCY = CORDIC_ITERS + 6;

  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(64'sd652032874);
  localparam logic signed [ZW-1:0] HALF_PI     = ZW'(64'sd1686629713);
  localparam logic signed [ZW-1:0] PI_VAL      = ZW'(64'sd3373259426);

  localparam logic signed [ZW-1:0] ATAN_Q30 [0:ATAN_LEN-1] = '{
    ZW'(64'sd843314857), ZW'(64'sd497837829), ZW'(64'sd263043837), ZW'(64'sd133525159),
    ZW'(64'sd67021687),  ZW'(64'sd33543516),  ZW'(64'sd16775851),  ZW'(64'sd8388437),
    ZW'(64'sd4194283),   ZW'(64'sd2097149),   ZW'(64'sd1048576),   ZW'(64'sd524288),
    ZW'(64'sd262144),    ZW'(64'sd131072),    ZW'(64'sd65536),     ZW'(64'sd32768),
    ZW'(64'sd16384),     ZW'(64'sd8192),      ZW'(64'sd4096),      ZW'(64'sd2048),
    ZW'(64'sd1024),      ZW'(64'sd512),       ZW'(64'sd256),       ZW'(64'sd128)
  };

  // Pair products: 0 cy*cp, 1 sy*sp, 2 sy*cp, 3 cy*sp.
  localparam int TERM_PP [0:TERMS-1] = '{0, 1, 0, 1, 2, 3, 2, 3};
  // Roll factor of each term: 1 selects the sine, 0 the cosine.
  localparam bit TERM_SIN [0:TERMS-1] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
  // Quaternion parts that subtract their second term.
  localparam bit QUAT_SUB [0:QUATS-1] = '{1'b0, 1'b1, 1'b0, 1'b1};

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [TW-1:0]      trig_t;
  typedef logic signed [QUAT_W-1:0]  quat_t;

endpackage

/* sv/euler_to_quaternion.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler to quaternion converter
// Turns roll, pitch and yaw in Q3.13 radians into a ZYX unit quaternion in
// Q1.14, saturated to plus or minus one.
// ----------------------------------------------------------------------------
// Usage: a beat is taken at each rising edge where start_i is high and busy_o
// is low. busy_o is always low, so one attitude sample can enter every cycle.
// Each beat gives exactly one result, shown on quat_w_o..quat_z_o for one
// cycle while valid_o is high, in the order the beats were taken.
// The pipeline has one fold stage, one CORDIC stage per micro-rotation, one
// rounding stage, then four product stages (pair products, split partial
// products, their sum, and the final add, round and saturate into the output
// register).
// Throughput is one beat per cycle; the CORDIC stage count sets the latency.
// Reset clears the valid bits of every stage, so no result appears for
// beats that were in flight. The receiver has no back-pressure: every result
// is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module euler_to_quaternion (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  euq_pkg::angle_t roll_angle_i,
  input  euq_pkg::angle_t pitch_angle_i,
  input  euq_pkg::angle_t yaw_angle_i,
  output logic            valid_o,
  output euq_pkg::quat_t  quat_w_o,
  output euq_pkg::quat_t  quat_x_o,
  output euq_pkg::quat_t  quat_y_o,
  output euq_pkg::quat_t  quat_z_o
);

  euq_pkg::angle_t angle [euq_pkg::LANES];
  euq_pkg::trig_t  cos_v [euq_pkg::LANES];
  euq_pkg::trig_t  sin_v [euq_pkg::LANES];
  euq_pkg::quat_t  quat  [euq_pkg::QUATS];
  logic            accept;
  logic            trig_valid;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign angle[euq_pkg::LANE_ROLL]  = roll_angle_i;
  assign angle[euq_pkg::LANE_PITCH] = pitch_angle_i;
  assign angle[euq_pkg::LANE_YAW]   = yaw_angle_i;

  euq_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .angle_i (angle),
    .valid_o (trig_valid),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  euq_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (trig_valid),
    .cos_i   (cos_v),
    .sin_i   (sin_v),
    .valid_o (valid_o),
    .quat_o  (quat)
  );

  assign quat_w_o = quat[0];
  assign quat_x_o = quat[1];
  assign quat_y_o = quat[2];
  assign quat_z_o = quat[3];

endmodule

/* sv/euq_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler to quaternion CORDIC pipeline
// Halves three angles, folds them into the right half plane and runs one
// rotation-mode micro-rotation per stage, then rounds cosine and sine.
// ----------------------------------------------------------------------------
module euq_cordic (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  euq_pkg::angle_t angle_i [euq_pkg::LANES],
  output logic            valid_o,
  output euq_pkg::trig_t  cos_o   [euq_pkg::LANES],
  output euq_pkg::trig_t  sin_o   [euq_pkg::LANES]
);

  localparam int N = euq_pkg::CORDIC_ITERS;

  logic                        vld_q [0:N+1];
  logic signed [euq_pkg::CW-1:0] x_q [0:N][euq_pkg::LANES];
  logic signed [euq_pkg::CW-1:0] y_q [0:N][euq_pkg::LANES];
  logic signed [euq_pkg::ZW-1:0] z_q [0:N][euq_pkg::LANES];
  logic                          ng_q [0:N][euq_pkg::LANES];

  logic signed [euq_pkg::ZW-1:0] z0_d  [euq_pkg::LANES];
  logic                          ng0_d [euq_pkg::LANES];

  euq_pkg::trig_t cos_q [euq_pkg::LANES];
  euq_pkg::trig_t sin_q [euq_pkg::LANES];
  euq_pkg::trig_t cos_d [euq_pkg::LANES];
  euq_pkg::trig_t sin_d [euq_pkg::LANES];

  always_comb begin
    logic signed [euq_pkg::ZW-1:0] h;
    for (int l = 0; l < euq_pkg::LANES; l++) begin
      h = euq_pkg::ZW'({angle_i[l], 16'b0});
      h = {{(euq_pkg::ZW - euq_pkg::ANGLE_W - 16){angle_i[l][euq_pkg::ANGLE_W-1]}},
           angle_i[l], 16'b0};
      if (h > euq_pkg::HALF_PI) begin
        z0_d[l]  = euq_pkg::PI_VAL - h;
        ng0_d[l] = 1'b1;
      end else if (h < -euq_pkg::HALF_PI) begin
        z0_d[l]  = -euq_pkg::PI_VAL - h;
        ng0_d[l] = 1'b1;
      end else begin
        z0_d[l]  = h;
        ng0_d[l] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < euq_pkg::LANES; l++) begin
      x_q[0][l]  <= euq_pkg::CORDIC_GAIN;
      y_q[0][l]  <= '0;
      z_q[0][l]  <= z0_d[l];
      ng_q[0][l] <= ng0_d[l];
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_iter
    logic signed [euq_pkg::CW-1:0] x_d [euq_pkg::LANES];
    logic signed [euq_pkg::CW-1:0] y_d [euq_pkg::LANES];
    logic signed [euq_pkg::ZW-1:0] z_d [euq_pkg::LANES];

    always_comb begin
      for (int l = 0; l < euq_pkg::LANES; l++) begin
        if (!z_q[k][l][euq_pkg::ZW-1]) begin
          x_d[l] = x_q[k][l] - (y_q[k][l] >>> k);
          y_d[l] = y_q[k][l] + (x_q[k][l] >>> k);
          z_d[l] = z_q[k][l] - euq_pkg::ATAN_Q30[k];
        end else begin
          x_d[l] = x_q[k][l] + (y_q[k][l] >>> k);
          y_d[l] = y_q[k][l] - (x_q[k][l] >>> k);
          z_d[l] = z_q[k][l] + euq_pkg::ATAN_Q30[k];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      for (int l = 0; l < euq_pkg::LANES; l++) begin
        x_q[k+1][l]  <= x_d[l];
        y_q[k+1][l]  <= y_d[l];
        z_q[k+1][l]  <= z_d[l];
        ng_q[k+1][l] <= ng_q[k][l];
      end
    end
  end

  always_comb begin
    logic signed [euq_pkg::CW-1:0] xs;
    logic signed [euq_pkg::CW-1:0] ys;
    for (int l = 0; l < euq_pkg::LANES; l++) begin
      xs = ng_q[N][l] ? -x_q[N][l] : x_q[N][l];
      xs = (xs + euq_pkg::CW'(1 << (euq_pkg::RND_SH - 1))) >>> euq_pkg::RND_SH;
      ys = (y_q[N][l] + euq_pkg::CW'(1 << (euq_pkg::RND_SH - 1))) >>> euq_pkg::RND_SH;
      cos_d[l] = xs[euq_pkg::TW-1:0];
      sin_d[l] = ys[euq_pkg::TW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < euq_pkg::LANES; l++) begin
      cos_q[l] <= cos_d[l];
      sin_q[l] <= sin_d[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= N + 1; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else begin
      vld_q[0] <= valid_i;
      for (int s = 1; s <= N + 1; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  assign valid_o = vld_q[N+1];
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;

endmodule

/* sv/euq_combine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler to quaternion product pipeline
// Forms the ZYX half-angle products in split partial products, sums them,
// rounds to Q1.14 and saturates to plus or minus one.
// ----------------------------------------------------------------------------
module euq_combine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  euq_pkg::trig_t cos_i  [euq_pkg::LANES],
  input  euq_pkg::trig_t sin_i  [euq_pkg::LANES],
  output logic           valid_o,
  output euq_pkg::quat_t quat_o [euq_pkg::QUATS]
);

  logic [3:0] vld_q;

  logic signed [euq_pkg::PPW-1:0] pp_q [4];
  euq_pkg::trig_t                 cr_q;
  euq_pkg::trig_t                 sr_q;

  logic signed [euq_pkg::PPW-1:0]  lo_q [euq_pkg::TERMS];
  logic signed [euq_pkg::PPW:0]    hi_q [euq_pkg::TERMS];
  logic signed [euq_pkg::PW-1:0]   tp_q [euq_pkg::TERMS];
  euq_pkg::quat_t                  quat_q [euq_pkg::QUATS];

  always_ff @(posedge clk_i) begin
    pp_q[0] <= cos_i[euq_pkg::LANE_YAW] * cos_i[euq_pkg::LANE_PITCH];
    pp_q[1] <= sin_i[euq_pkg::LANE_YAW] * sin_i[euq_pkg::LANE_PITCH];
    pp_q[2] <= sin_i[euq_pkg::LANE_YAW] * cos_i[euq_pkg::LANE_PITCH];
    pp_q[3] <= cos_i[euq_pkg::LANE_YAW] * sin_i[euq_pkg::LANE_PITCH];
    cr_q    <= cos_i[euq_pkg::LANE_ROLL];
    sr_q    <= sin_i[euq_pkg::LANE_ROLL];
  end

  for (genvar t = 0; t < euq_pkg::TERMS; t++) begin : g_term
    logic signed [euq_pkg::PPW-1:0]  a;
    logic signed [euq_pkg::LO_W:0]   a_lo;
    logic signed [euq_pkg::HI_W-1:0] a_hi;
    euq_pkg::trig_t                  b;

    always_comb begin
      a    = pp_q[euq_pkg::TERM_PP[t]];
      a_lo = {1'b0, a[euq_pkg::LO_W-1:0]};
      a_hi = a[euq_pkg::PPW-1:euq_pkg::LO_W];
      b    = euq_pkg::TERM_SIN[t] ? sr_q : cr_q;
    end

    always_ff @(posedge clk_i) begin
      lo_q[t] <= a_lo * b;
      hi_q[t] <= a_hi * b;
      tp_q[t] <= (euq_pkg::PW'(hi_q[t]) <<< euq_pkg::LO_W) + euq_pkg::PW'(lo_q[t]);
    end
  end

  for (genvar q = 0; q < euq_pkg::QUATS; q++) begin : g_quat
    logic signed [euq_pkg::SW-1:0] s;
    logic signed [euq_pkg::SW-1:0] r;
    logic signed [euq_pkg::RW-1:0] rr;
    euq_pkg::quat_t                quat_d;

    always_comb begin
      if (euq_pkg::QUAT_SUB[q]) begin
        s = euq_pkg::SW'(tp_q[2*q]) - euq_pkg::SW'(tp_q[2*q+1]);
      end else begin
        s = euq_pkg::SW'(tp_q[2*q]) + euq_pkg::SW'(tp_q[2*q+1]);
      end
      r  = (s + (euq_pkg::SW'(1) << (euq_pkg::OUT_SH - 1))) >>> euq_pkg::OUT_SH;
      rr = r[euq_pkg::RW-1:0];
      if (rr > euq_pkg::RW'(euq_pkg::Q14_ONE)) begin
        quat_d = euq_pkg::QUAT_W'(euq_pkg::Q14_ONE);
      end else if (rr < -euq_pkg::RW'(euq_pkg::Q14_ONE)) begin
        quat_d = -euq_pkg::QUAT_W'(euq_pkg::Q14_ONE);
      end else begin
        quat_d = rr[euq_pkg::QUAT_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      quat_q[q] <= quat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  assign valid_o = vld_q[3];
  assign quat_o  = quat_q;

endmodule

/* sv/euq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler to quaternion port checker
// Watches the top-level ports for beat timing and result range.
// ----------------------------------------------------------------------------
`include "euler_to_quaternion_assert.svh"

module euq_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input logic           valid_o,
  input euq_pkg::quat_t quat_w_o,
  input euq_pkg::quat_t quat_x_o,
  input euq_pkg::quat_t quat_y_o,
  input euq_pkg::quat_t quat_z_o
);

  logic quat_in_range;

  assign quat_in_range = (quat_w_o <= 16'sd16384) && (quat_w_o >= -16'sd16384) &&
                         (quat_x_o <= 16'sd16384) && (quat_x_o >= -16'sd16384) &&
                         (quat_y_o <= 16'sd16384) && (quat_y_o >= -16'sd16384) &&
                         (quat_z_o <= 16'sd16384) && (quat_z_o >= -16'sd16384);

  `EUQ_ASSERT_IMP(a_beat_gives_result, start_i && !busy_o, ##(euq_pkg::LATENCY) valid_o, "lost")
  `EUQ_ASSERT_IMP(a_result_has_beat, valid_o, $past(start_i && !busy_o, euq_pkg::LATENCY), "extra")
  `EUQ_ASSERT_IMP(a_quat_range, valid_o, quat_in_range, "quaternion part out of range")
  `EUQ_ASSERT_ALWAYS(a_never_busy, !busy_o, "busy raised on a stall-free pipeline")

endmodule

bind euler_to_quaternion euq_checker u_euq_checker (.*);
